[src/mera_pkg.sv]
// shared types, constants and helper functions for the mouse report accumulator
package mera_pkg;

  localparam int NUM_BUTTONS = 8;

  localparam int CODE_W = 10;
  localparam int VALUE_W = 32;
  localparam int MASK_W = 16;
  localparam int MOVE_W = 16;
  localparam int WHEEL_W = 8;
  localparam int BTN_IDX_W = 4;

  typedef enum logic [1:0] {
    OP_REL     = 2'd0,
    OP_BUTTON  = 2'd1,
    OP_EXTRACT = 2'd2
  } opcode_t;

  localparam logic [CODE_W-1:0] AXIS_X = 10'd0;
  localparam logic [CODE_W-1:0] AXIS_Y = 10'd1;
  localparam logic [CODE_W-1:0] AXIS_HWHEEL = 10'd6;
  localparam logic [CODE_W-1:0] AXIS_WHEEL = 10'd8;

  localparam logic [CODE_W-1:0] BTN_BASE = 10'h110;
  localparam logic [CODE_W-1:0] BTN_END = CODE_W'(BTN_BASE + NUM_BUTTONS);

  localparam logic signed [VALUE_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] ACC_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] MOVE_HI = 32'sd32767;
  localparam logic signed [VALUE_W-1:0] MOVE_LO = -32'sd32768;
  localparam logic signed [VALUE_W-1:0] WHEEL_HI = 32'sd127;
  localparam logic signed [VALUE_W-1:0] WHEEL_LO = -32'sd128;

  typedef struct packed {
    logic                      valid;
    opcode_t                   op;
    logic [CODE_W-1:0]         code;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  function automatic logic signed [VALUE_W-1:0] sat_add(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    logic signed [VALUE_W:0] s;
    s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    // sign of the wide sum picks the rail on overflow
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      return s[VALUE_W] ? ACC_MIN : ACC_MAX;
    end
    return s[VALUE_W-1:0];
  endfunction

  function automatic logic signed [MOVE_W-1:0] clamp_move(
    input logic signed [VALUE_W-1:0] v
  );
    if (v > MOVE_HI) begin
      return MOVE_HI[MOVE_W-1:0];
    end else if (v < MOVE_LO) begin
      return MOVE_LO[MOVE_W-1:0];
    end
    return v[MOVE_W-1:0];
  endfunction

  function automatic logic signed [WHEEL_W-1:0] clamp_wheel(
    input logic signed [VALUE_W-1:0] v
  );
    if (v > WHEEL_HI) begin
      return WHEEL_HI[WHEEL_W-1:0];
    end else if (v < WHEEL_LO) begin
      return WHEEL_LO[WHEEL_W-1:0];
    end
    return v[WHEEL_W-1:0];
  endfunction

endpackage

[src/mera_in_stage.sv]
// input register stage holding one event transaction
module mera_in_stage (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_opcode,
  input  logic [mera_pkg::CODE_W-1:0]        in_event_code,
  input  logic signed [mera_pkg::VALUE_W-1:0] in_event_value,
  input  logic                               take,
  output mera_pkg::item_t                    item
);
  import mera_pkg::*;

  item_t item_r;
  item_t item_nxt;

  // stage frees up in the same cycle the core consumes it
  assign in_ready = !item_r.valid || take;
  assign item = item_r;

  always_comb begin
    item_nxt = item_r;
    if (in_valid && in_ready) begin
      item_nxt.valid = 1'b1;
      item_nxt.op    = opcode_t'(in_opcode);
      item_nxt.code  = in_event_code;
      item_nxt.value = in_event_value;
    end else if (take) begin
      item_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r.valid <= item_nxt.valid;
    end
    item_r.op    <= item_nxt.op;
    item_r.code  <= item_nxt.code;
    item_r.value <= item_nxt.value;
  end

endmodule

[src/mera_acc_core.sv]
// accumulators, button mask and the report output register
module mera_acc_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mera_pkg::item_t                     item,
  output logic                                take,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mera_pkg::MASK_W-1:0]         out_button_mask,
  output logic signed [mera_pkg::MOVE_W-1:0]  out_move_x,
  output logic signed [mera_pkg::MOVE_W-1:0]  out_move_y,
  output logic signed [mera_pkg::WHEEL_W-1:0] out_wheel,
  output logic signed [mera_pkg::WHEEL_W-1:0] out_hwheel
);
  import mera_pkg::*;

  logic signed [VALUE_W-1:0] acc_x_r, acc_x_nxt;
  logic signed [VALUE_W-1:0] acc_y_r, acc_y_nxt;
  logic signed [VALUE_W-1:0] acc_wheel_r, acc_wheel_nxt;
  logic signed [VALUE_W-1:0] acc_hwheel_r, acc_hwheel_nxt;
  logic [MASK_W-1:0]         held_r, held_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]         mask_r;
  logic signed [MOVE_W-1:0]  move_x_r, move_y_r;
  logic signed [WHEEL_W-1:0] wheel_r, hwheel_r;

  logic                      is_extract;
  logic                      load_report;
  logic [BTN_IDX_W-1:0]      btn_idx;

  assign is_extract = item.valid && (item.op == OP_EXTRACT);
  // only an extract can stall, and only on a full report register
  assign take = item.valid && (!is_extract || !out_valid_r || out_ready);
  assign load_report = take && is_extract;
  assign btn_idx = BTN_IDX_W'(item.code - BTN_BASE);

  always_comb begin
    acc_x_nxt      = acc_x_r;
    acc_y_nxt      = acc_y_r;
    acc_wheel_nxt  = acc_wheel_r;
    acc_hwheel_nxt = acc_hwheel_r;
    held_nxt       = held_r;
    if (take) begin
      unique case (item.op)
        OP_REL: begin
          if (item.code == AXIS_X) begin
            acc_x_nxt = sat_add(acc_x_r, item.value);
          end else if (item.code == AXIS_Y) begin
            acc_y_nxt = sat_add(acc_y_r, item.value);
          end else if (item.code == AXIS_WHEEL) begin
            acc_wheel_nxt = sat_add(acc_wheel_r, item.value);
          end else if (item.code == AXIS_HWHEEL) begin
            acc_hwheel_nxt = sat_add(acc_hwheel_r, item.value);
          end
        end
        OP_BUTTON: begin
          if (item.code >= BTN_BASE && item.code < BTN_END) begin
            held_nxt[btn_idx] = (item.value != '0);
          end
        end
        OP_EXTRACT: begin
          acc_x_nxt      = '0;
          acc_y_nxt      = '0;
          acc_wheel_nxt  = '0;
          acc_hwheel_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_report) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r      <= '0;
      acc_y_r      <= '0;
      acc_wheel_r  <= '0;
      acc_hwheel_r <= '0;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      acc_x_r      <= acc_x_nxt;
      acc_y_r      <= acc_y_nxt;
      acc_wheel_r  <= acc_wheel_nxt;
      acc_hwheel_r <= acc_hwheel_nxt;
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_report) begin
      mask_r   <= held_r;
      move_x_r <= clamp_move(acc_x_r);
      move_y_r <= clamp_move(acc_y_r);
      wheel_r  <= clamp_wheel(acc_wheel_r);
      hwheel_r <= clamp_wheel(acc_hwheel_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_button_mask = mask_r;
  assign out_move_x      = move_x_r;
  assign out_move_y      = move_y_r;
  assign out_wheel       = wheel_r;
  assign out_hwheel      = hwheel_r;

endmodule

[src/mouse_event_report_accumulator_top.sv]
// path: an accepted extract is held in the input stage register, then its report is loaded
// into the report output register, once that register is not stalled on the output side
// throughput: one event per cycle; only an extract waiting on a full report register stalls
// reset: synchronous active-low rst_n clears accumulators, held button mask and all valid flags
// top level of the mouse event report accumulator
module mouse_event_report_accumulator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_opcode,
  input  logic [mera_pkg::CODE_W-1:0]         in_event_code,
  input  logic signed [mera_pkg::VALUE_W-1:0] in_event_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mera_pkg::MASK_W-1:0]         out_button_mask,
  output logic signed [mera_pkg::MOVE_W-1:0]  out_move_x,
  output logic signed [mera_pkg::MOVE_W-1:0]  out_move_y,
  output logic signed [mera_pkg::WHEEL_W-1:0] out_wheel,
  output logic signed [mera_pkg::WHEEL_W-1:0] out_hwheel
);
  import mera_pkg::*;

  item_t item;
  logic  take;

  mera_in_stage u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_event_code (in_event_code),
    .in_event_value(in_event_value),
    .take          (take),
    .item          (item)
  );

  mera_acc_core u_acc_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (item),
    .take           (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_button_mask(out_button_mask),
    .out_move_x     (out_move_x),
    .out_move_y     (out_move_y),
    .out_wheel      (out_wheel),
    .out_hwheel     (out_hwheel)
  );

endmodule

[src/mera_checker.sv]
// port-level assertions for the accumulator top level, bound in below
module mera_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [1:0]                          in_opcode,
  input logic [mera_pkg::CODE_W-1:0]         in_event_code,
  input logic signed [mera_pkg::VALUE_W-1:0] in_event_value,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [mera_pkg::MASK_W-1:0]         out_button_mask,
  input logic signed [mera_pkg::MOVE_W-1:0]  out_move_x,
  input logic signed [mera_pkg::MOVE_W-1:0]  out_move_y,
  input logic signed [mera_pkg::WHEEL_W-1:0] out_wheel,
  input logic signed [mera_pkg::WHEEL_W-1:0] out_hwheel
);

  // no report survives a reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("report valid after reset");

  // input backpressure only comes from a stalled report
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked report");

  // a waiting input transaction keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_opcode) && $stable(in_event_code)
      && $stable(in_event_value))
    else $error("input transaction changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("report dropped before transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_button_mask) && $stable(out_move_x)
      && $stable(out_move_y) && $stable(out_wheel) && $stable(out_hwheel))
    else $error("stalled report changed");

endmodule

bind mouse_event_report_accumulator_top mera_checker u_mera_checker (.*);

[bench/mouse_event_report_accumulator_top_test.sv]
// testbench for the mouse event report accumulator: directed and random event streams checked against a predictor
`timescale 1ns / 100ps

module mouse_event_report_accumulator_top_test;
  import mera_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 6;
  localparam longint ACC_HI = 64'sd2147483647;
  localparam longint ACC_LO = -64'sd2147483648;

  typedef struct {
    logic [1:0]          op;
    logic [CODE_W-1:0]   code;
    logic [VALUE_W-1:0]  value;
  } mouse_evt_t;

  typedef struct {
    logic [MASK_W-1:0]         mask;
    logic signed [MOVE_W-1:0]  move_x;
    logic signed [MOVE_W-1:0]  move_y;
    logic signed [WHEEL_W-1:0] wheel;
    logic signed [WHEEL_W-1:0] hwheel;
  } mouse_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = OP_NONE;
  logic [CODE_W-1:0] in_event_code = '0;
  logic signed [VALUE_W-1:0] in_event_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [MASK_W-1:0] out_button_mask;
  logic signed [MOVE_W-1:0] out_move_x;
  logic signed [MOVE_W-1:0] out_move_y;
  logic signed [WHEEL_W-1:0] out_wheel;
  logic signed [WHEEL_W-1:0] out_hwheel;

  mouse_event_report_accumulator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_event_code   (in_event_code),
    .in_event_value  (in_event_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_button_mask (out_button_mask),
    .out_move_x      (out_move_x),
    .out_move_y      (out_move_y),
    .out_wheel       (out_wheel),
    .out_hwheel      (out_hwheel)
  );

  mouse_evt_t    evt_pending[$];
  mouse_report_t reports_due[$];

  // predicted device state
  longint          sum_x, sum_y, sum_wheel, sum_hwheel;
  logic [MASK_W-1:0] buttons_held;

  int send_idle = 34;
  int recv_idle = 86;
  int errors = 0;
  int n_queued = 0;
  int n_taken = 0;
  int n_motion = 0, n_button = 0, n_ignored = 0, n_saturated = 0, n_reports = 0;
  int idle_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic note_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint bound(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic add_motion(inout longint acc, input longint delta);
    longint raw;
    raw = acc + delta;
    if (raw > ACC_HI || raw < ACC_LO) n_saturated++;
    acc = bound(raw, ACC_LO, ACC_HI);
  endtask

  // predictor: one accepted transaction in, at most one report queued
  task automatic apply_event(input logic [1:0] op, input logic [CODE_W-1:0] code,
                             input logic signed [VALUE_W-1:0] value);
    longint delta;
    int idx;
    mouse_report_t rpt;
    delta = longint'(value);
    if (op == OP_REL) begin
      if (code == AXIS_X) add_motion(sum_x, delta);
      else if (code == AXIS_Y) add_motion(sum_y, delta);
      else if (code == AXIS_WHEEL) add_motion(sum_wheel, delta);
      else if (code == AXIS_HWHEEL) add_motion(sum_hwheel, delta);
      else n_ignored++;
      n_motion++;
    end else if (op == OP_BUTTON) begin
      if (int'(code) >= int'(BTN_BASE) && int'(code) < int'(BTN_BASE) + NUM_BUTTONS) begin
        idx = int'(code) - int'(BTN_BASE);
        buttons_held[idx] = (value != 0);
      end else begin
        n_ignored++;
      end
      n_button++;
    end else if (op == OP_EXTRACT) begin
      rpt.mask = buttons_held;
      rpt.move_x = MOVE_W'(bound(sum_x, -32768, 32767));
      rpt.move_y = MOVE_W'(bound(sum_y, -32768, 32767));
      rpt.wheel = WHEEL_W'(bound(sum_wheel, -128, 127));
      rpt.hwheel = WHEEL_W'(bound(sum_hwheel, -128, 127));
      reports_due = {reports_due, rpt};
      sum_x = 0;
      sum_y = 0;
      sum_wheel = 0;
      sum_hwheel = 0;
    end else begin
      n_ignored++;
    end
  endtask

  task automatic queue_event(input logic [1:0] op, input logic [CODE_W-1:0] code,
                             input logic [VALUE_W-1:0] value);
    mouse_evt_t e;
    e.op = op;
    e.code = code;
    e.value = value;
    evt_pending = {evt_pending, e};
    n_queued++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_delta();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($urandom_range(40)) - 32'd20;
      4, 5:       return 32'($urandom_range(70000)) - 32'd35000;
      6:          return 32'($urandom_range(400)) - 32'd200;
      7, 8:       return $urandom();
      default: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h8000_0001;
          3: return 32'h7FFF_FFFE;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // a burst of events closed by an extract, with some noise mixed in
  task automatic queue_burst();
    int n;
    int r;
    logic [CODE_W-1:0] axis;
    n = $urandom_range(12, 1);
    repeat (n) begin
      r = $urandom_range(99);
      case ($urandom_range(3))
        0: axis = AXIS_X;
        1: axis = AXIS_Y;
        2: axis = AXIS_WHEEL;
        default: axis = AXIS_HWHEEL;
      endcase
      if (r < 55) begin
        queue_event(OP_REL, axis, pick_delta());
      end else if (r < 85) begin
        queue_event(OP_BUTTON, CODE_W'(int'(BTN_BASE) + $urandom_range(NUM_BUTTONS - 1)),
                    ($urandom_range(2) == 0) ? 32'd0 : $urandom());
      end else if (r < 92) begin
        queue_event(OP_REL, CODE_W'($urandom_range(1023)), pick_delta());
      end else if (r < 97) begin
        queue_event(OP_BUTTON, CODE_W'($urandom_range(1023)), $urandom());
      end else begin
        queue_event(OP_NONE, CODE_W'($urandom_range(1023)), $urandom());
      end
    end
    // occasionally an extract right behind another one
    if ($urandom_range(9) == 0) queue_event(OP_EXTRACT, CODE_W'($urandom_range(1023)), $urandom());
    queue_event(OP_EXTRACT, CODE_W'($urandom_range(1023)), $urandom());
  endtask

  // sender pauses until every transaction is taken and every report has come back
  task automatic drain();
    while (n_taken != n_queued) @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin : drive_in
    mouse_evt_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (evt_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt = evt_pending.pop_front();
        in_valid <= 1'b1;
        in_opcode <= nxt.op;
        in_event_code <= nxt.code;
        in_event_value <= nxt.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on input transactions, check output transactions, watchdog
  always @(posedge clk) begin : watch
    mouse_report_t want;
    logic took_in;
    logic took_out;
    took_in = rst_n && in_valid && in_ready;
    took_out = rst_n && out_valid && out_ready;
    if (took_in) begin
      apply_event(in_opcode, in_event_code, in_event_value);
      n_taken++;
    end
    if (took_out) begin
      if (reports_due.size() == 0) begin
        note_error("report with none expected");
      end else begin
        want = reports_due.pop_front();
        if (out_button_mask !== want.mask)
          note_error($sformatf("report %0d button_mask got %h want %h",
                               n_reports, out_button_mask, want.mask));
        if (out_move_x !== want.move_x)
          note_error($sformatf("report %0d move_x got %0d want %0d",
                               n_reports, out_move_x, want.move_x));
        if (out_move_y !== want.move_y)
          note_error($sformatf("report %0d move_y got %0d want %0d",
                               n_reports, out_move_y, want.move_y));
        if (out_wheel !== want.wheel)
          note_error($sformatf("report %0d wheel got %0d want %0d",
                               n_reports, out_wheel, want.wheel));
        if (out_hwheel !== want.hwheel)
          note_error($sformatf("report %0d hwheel got %0d want %0d",
                               n_reports, out_hwheel, want.hwheel));
      end
      n_reports++;
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
    if (took_in || took_out || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("** mouse_event_report_accumulator_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int target;
    sum_x = 0;
    sum_y = 0;
    sum_wheel = 0;
    sum_hwheel = 0;
    buttons_held = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: each axis, button edges, saturation, clamping, ignored codes
    queue_event(OP_EXTRACT, 10'd0, 32'd0);
    queue_event(OP_REL, AXIS_X, 32'd5);
    queue_event(OP_REL, AXIS_Y, -32'sd3);
    queue_event(OP_REL, AXIS_WHEEL, 32'd2);
    queue_event(OP_REL, AXIS_HWHEEL, -32'sd1);
    queue_event(OP_EXTRACT, 10'h3FF, 32'hFFFF_FFFF);
    queue_event(OP_BUTTON, BTN_BASE, 32'd1);
    queue_event(OP_BUTTON, CODE_W'(int'(BTN_BASE) + NUM_BUTTONS - 1), 32'h8000_0000);
    queue_event(OP_BUTTON, BTN_END, 32'd1);
    queue_event(OP_BUTTON, BTN_BASE - 10'd1, 32'd1);
    queue_event(OP_REL, AXIS_X, 32'h7FFF_FFFF);
    queue_event(OP_REL, AXIS_X, 32'h7FFF_FFFF);
    queue_event(OP_REL, AXIS_Y, 32'h8000_0000);
    queue_event(OP_REL, AXIS_Y, 32'h8000_0000);
    queue_event(OP_REL, AXIS_WHEEL, 32'd200);
    queue_event(OP_REL, AXIS_HWHEEL, -32'sd300);
    queue_event(OP_EXTRACT, 10'd0, 32'd0);
    queue_event(OP_REL, 10'd2, 32'd77);
    queue_event(OP_REL, 10'h3FF, 32'h7FFF_FFFF);
    queue_event(OP_NONE, 10'h3FF, 32'hFFFF_FFFF);
    queue_event(OP_BUTTON, BTN_BASE, 32'd0);
    queue_event(OP_REL, AXIS_X, -32'sd32769);
    queue_event(OP_REL, AXIS_Y, 32'd32768);
    queue_event(OP_EXTRACT, 10'd0, 32'd0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 34; recv_idle = 86; end
        1: begin send_idle = 86; recv_idle = 34; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      target = (phase == 2) ? 950 : 320 * (phase + 1);
      while (n_queued < target) queue_burst();
      drain();
    end

    $display("covered %0d relative and %0d button events, %0d ignored, %0d saturating sums",
             n_motion, n_button, n_ignored, n_saturated);
    $display("checked %0d reports over three idling mixes", n_reports);
    if (errors == 0) begin
      $display("** mouse_event_report_accumulator_top: PASSED **");
    end else begin
      $display("** mouse_event_report_accumulator_top: FAILED **");
    end
    $finish;
  end

endmodule
